@@ sv/axis_vector_rotation_defines.svh @@
// Assertion macros for the vector rotation RTL.
// Included by avr_cell, which checks its own pipeline behavior; no dependencies.
`ifndef AXIS_VECTOR_ROTATION_DEFINES_SVH
`define AXIS_VECTOR_ROTATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AVR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/avr_pkg.sv @@
// Shared types, constants and the arctangent table for the vector rotation block.
// No dependencies; every RTL module and the testbench import this package.
package avr_pkg;

    // Field widths of the beats and internal datapath widths.
    localparam int COORD_BITS = 32;
    localparam int ANGLE_BITS = 16;
    localparam int PHASE_BITS = 32;
    localparam int GUARD_BITS = 8;
    localparam int WORK_BITS  = COORD_BITS + GUARD_BITS + 3;

    // Gain correction: 1/K as unsigned Q0.32.
    localparam int GAIN_BITS = 32;
    localparam logic [GAIN_BITS-1:0] INV_GAIN = 32'd2608131496;

    // Magnitude path widths in the gain correction stages.
    localparam int MAG_BITS = (WORK_BITS > GAIN_BITS) ? WORK_BITS : GAIN_BITS + 1;
    localparam int HI_BITS  = MAG_BITS - GAIN_BITS;
    localparam int SUM_BITS = MAG_BITS + 1;
    localparam int RND_BITS = SUM_BITS - GUARD_BITS;

    // Rotation axis selector.
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // Control that travels alongside the data in every pipeline stage before the output register.
    typedef struct packed {
        logic  valid;
        t_axis op;
    } t_flow;

    typedef struct packed {
        logic [1:0]                   op;
        logic signed [COORD_BITS-1:0] x_in;
        logic signed [COORD_BITS-1:0] y_in;
        logic signed [COORD_BITS-1:0] z_in;
        logic [ANGLE_BITS-1:0]        turn_angle;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_out;
        logic signed [COORD_BITS-1:0] y_out;
        logic signed [COORD_BITS-1:0] z_out;
    } t_out_beat;

    // atan(2^-step) in 32-bit turns; zero once the angle drops below half an LSB.
    function automatic logic [PHASE_BITS-1:0] atan_turn(input int step);
        logic [PHASE_BITS-1:0] res;
        case (step)
            0:       res = 32'h2000_0000;
            1:       res = 32'h12E4_051E;
            2:       res = 32'h09FB_385B;
            3:       res = 32'h0511_11D4;
            4:       res = 32'h028B_0D43;
            5:       res = 32'h0145_D7E1;
            6:       res = 32'h00A2_F61E;
            7:       res = 32'h0051_7C55;
            8:       res = 32'h0028_BE53;
            9:       res = 32'h0014_5F2F;
            10:      res = 32'h000A_2F98;
            11:      res = 32'h0005_17CC;
            12:      res = 32'h0002_8BE6;
            13:      res = 32'h0001_45F3;
            14:      res = 32'h0000_A2FA;
            15:      res = 32'h0000_517D;
            16:      res = 32'h0000_28BE;
            17:      res = 32'h0000_145F;
            18:      res = 32'h0000_0A30;
            19:      res = 32'h0000_0518;
            20:      res = 32'h0000_028C;
            21:      res = 32'h0000_0146;
            22:      res = 32'h0000_00A3;
            23:      res = 32'h0000_0051;
            24:      res = 32'h0000_0029;
            25:      res = 32'h0000_0014;
            26:      res = 32'h0000_000A;
            27:      res = 32'h0000_0005;
            28:      res = 32'h0000_0003;
            29:      res = 32'h0000_0001;
            30:      res = 32'h0000_0001;
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

@@ sv/avr_cell.sv @@
// One CORDIC micro-rotation cell with its own pipeline register and handshake.
// Depends on avr_pkg and axis_vector_rotation_defines.svh.
`include "axis_vector_rotation_defines.svh"

module avr_cell #(
    parameter int STEP = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  avr_pkg::t_flow                        i_flow,
    output logic                                  o_ready,
    input  logic [avr_pkg::COORD_BITS-1:0]        i_pass,
    input  logic signed [avr_pkg::WORK_BITS-1:0]  i_a,
    input  logic signed [avr_pkg::WORK_BITS-1:0]  i_b,
    input  logic signed [avr_pkg::PHASE_BITS-1:0] i_z,
    output avr_pkg::t_flow                        o_flow,
    input  logic                                  i_ready,
    output logic [avr_pkg::COORD_BITS-1:0]        o_pass,
    output logic signed [avr_pkg::WORK_BITS-1:0]  o_a,
    output logic signed [avr_pkg::WORK_BITS-1:0]  o_b,
    output logic signed [avr_pkg::PHASE_BITS-1:0] o_z
);
    import avr_pkg::*;

    localparam logic [PHASE_BITS-1:0] ATAN = atan_turn(STEP);
    // The residual angle never leaves an eighth of a turn on either side of zero.
    localparam logic signed [PHASE_BITS-1:0] Z_LIMIT = PHASE_BITS'(1) <<< (PHASE_BITS - 3);

    t_flow                        r_flow;
    logic [COORD_BITS-1:0]        r_pass;
    logic signed [WORK_BITS-1:0]  r_a;
    logic signed [WORK_BITS-1:0]  r_b;
    logic signed [PHASE_BITS-1:0] r_z;
    logic signed [WORK_BITS-1:0]  n_a;
    logic signed [WORK_BITS-1:0]  n_b;
    logic signed [PHASE_BITS-1:0] n_z;
    logic signed [WORK_BITS-1:0]  w_da;
    logic signed [WORK_BITS-1:0]  w_db;

    // The register takes a new beat when it is empty or its beat moves on.
    assign o_ready = !r_flow.valid || i_ready;

    // Rotate toward a zero residual; pass-through beats keep their pair.
    always_comb begin
        w_da = i_b >>> STEP;
        w_db = i_a >>> STEP;
        if (i_flow.op == AXIS_NONE) begin
            n_a = i_a;
            n_b = i_b;
            n_z = i_z;
        end else if (!i_z[PHASE_BITS-1]) begin
            n_a = i_a - w_da;
            n_b = i_b + w_db;
            n_z = i_z - ATAN;
        end else begin
            n_a = i_a + w_da;
            n_b = i_b - w_db;
            n_z = i_z + ATAN;
        end
    end

    // Control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow <= '0;
        end else if (o_ready) begin
            r_flow <= i_flow;
        end
    end

    // Data register.
    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_pass <= i_pass;
            r_a    <= n_a;
            r_b    <= n_b;
            r_z    <= n_z;
        end
    end

    assign o_flow = r_flow;
    assign o_pass = r_pass;
    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_z    = r_z;

    `AVR_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n,
        r_flow.valid && !i_ready,
        r_flow.valid && $stable(r_a) && $stable(r_b) && $stable(r_z),
        "cell lost or changed a stalled beat")
    `AVR_ASSERT_SAME(a_residual_bound, i_clk, i_rst_n,
        r_flow.valid && r_flow.op != AXIS_NONE,
        (r_z <= Z_LIMIT) && (r_z >= -Z_LIMIT),
        "residual angle out of range")
    `AVR_ASSERT_SAME(a_bypass_aligned, i_clk, i_rst_n,
        r_flow.valid && r_flow.op == AXIS_NONE,
        (r_a[GUARD_BITS-1:0] == '0) && (r_b[GUARD_BITS-1:0] == '0),
        "pass-through pair was altered")

endmodule

@@ sv/avr_finish.sv @@
// Gain correction, rounding, saturation and output register for the rotated pair.
// Depends on avr_pkg.
module avr_finish (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  avr_pkg::t_flow                       i_flow,
    output logic                                 o_ready,
    input  logic [avr_pkg::COORD_BITS-1:0]       i_pass,
    input  logic signed [avr_pkg::WORK_BITS-1:0] i_a,
    input  logic signed [avr_pkg::WORK_BITS-1:0] i_b,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output avr_pkg::t_out_beat                   o_data
);
    import avr_pkg::*;

    localparam logic [RND_BITS-1:0] POS_MAX = RND_BITS'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam logic [RND_BITS-1:0] NEG_MAX = RND_BITS'(64'd1 << (COORD_BITS - 1));
    localparam logic [SUM_BITS-1:0] HALF    = SUM_BITS'(1) << (GUARD_BITS - 1);

    // Stage 1: sign and magnitude.
    t_flow                 r_flow1;
    logic [COORD_BITS-1:0] r_pass1;
    logic                  r_neg1 [2];
    logic [MAG_BITS-1:0]   r_mag1 [2];
    logic [COORD_BITS-1:0] r_raw1 [2];
    // Stage 2: partial products with 1/K.
    t_flow                 r_flow2;
    logic [COORD_BITS-1:0] r_pass2;
    logic                  r_neg2 [2];
    logic [MAG_BITS-1:0]   r_phi2 [2];
    logic [GAIN_BITS-1:0]  r_plo2 [2];
    logic [COORD_BITS-1:0] r_raw2 [2];
    // Stage 3: rounded magnitude.
    t_flow                 r_flow3;
    logic [COORD_BITS-1:0] r_pass3;
    logic                  r_neg3 [2];
    logic [RND_BITS-1:0]   r_rnd3 [2];
    logic [COORD_BITS-1:0] r_raw3 [2];
    // Stage 4: output register.
    logic                  r_out_valid;
    t_out_beat             r_out_data;

    logic                        w_rdy1;
    logic                        w_rdy2;
    logic                        w_rdy3;
    logic                        w_rdy4;
    logic signed [WORK_BITS-1:0] w_in [2];
    logic [MAG_BITS-1:0]         n_mag [2];
    logic [COORD_BITS-1:0]       n_raw [2];
    logic [MAG_BITS-1:0]         n_phi [2];
    logic [2*GAIN_BITS-1:0]      w_plo [2];
    logic [SUM_BITS-1:0]         w_sum [2];
    logic [COORD_BITS-1:0]       w_lim [2];
    logic [COORD_BITS-1:0]       w_val [2];
    t_out_beat                   n_out_data;

    // Backpressure: each stage loads when empty or when its beat moves on.
    assign w_rdy4  = !r_out_valid || i_ready;
    assign w_rdy3  = !r_flow3.valid || w_rdy4;
    assign w_rdy2  = !r_flow2.valid || w_rdy3;
    assign w_rdy1  = !r_flow1.valid || w_rdy2;
    assign o_ready = w_rdy1;

    // Per-lane arithmetic of all four stages.
    always_comb begin
        w_in[0] = i_a;
        w_in[1] = i_b;
        for (int l = 0; l < 2; l++) begin
            n_mag[l] = MAG_BITS'(w_in[l][WORK_BITS-1] ? -w_in[l] : w_in[l]);
            n_raw[l] = w_in[l][COORD_BITS+GUARD_BITS-1:GUARD_BITS];
            n_phi[l] = MAG_BITS'(r_mag1[l][MAG_BITS-1 -: HI_BITS]) * MAG_BITS'(INV_GAIN);
            w_plo[l] = (2*GAIN_BITS)'(r_mag1[l][GAIN_BITS-1:0]) * (2*GAIN_BITS)'(INV_GAIN);
            w_sum[l] = SUM_BITS'(r_phi2[l]) + SUM_BITS'(r_plo2[l]) + HALF;
            // Saturate the magnitude to the limit of its sign, then put the sign back.
            if (r_neg3[l]) begin
                w_lim[l] = (r_rnd3[l] > NEG_MAX) ? NEG_MAX[COORD_BITS-1:0]
                                                 : r_rnd3[l][COORD_BITS-1:0];
                w_val[l] = -w_lim[l];
            end else begin
                w_lim[l] = (r_rnd3[l] > POS_MAX) ? POS_MAX[COORD_BITS-1:0]
                                                 : r_rnd3[l][COORD_BITS-1:0];
                w_val[l] = w_lim[l];
            end
            if (r_flow3.op == AXIS_NONE) begin
                w_val[l] = r_raw3[l];
            end
        end
    end

    // Put the pair back on the axes it came from.
    always_comb begin
        case (r_flow3.op)
            AXIS_X: begin
                n_out_data.x_out = r_pass3;
                n_out_data.y_out = w_val[0];
                n_out_data.z_out = w_val[1];
            end
            AXIS_Y: begin
                n_out_data.x_out = w_val[1];
                n_out_data.y_out = r_pass3;
                n_out_data.z_out = w_val[0];
            end
            default: begin
                n_out_data.x_out = w_val[0];
                n_out_data.y_out = w_val[1];
                n_out_data.z_out = r_pass3;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow1     <= '0;
            r_flow2     <= '0;
            r_flow3     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_flow1 <= i_flow;
            end
            if (w_rdy2) begin
                r_flow2 <= r_flow1;
            end
            if (w_rdy3) begin
                r_flow3 <= r_flow2;
            end
            if (w_rdy4) begin
                r_out_valid <= r_flow3.valid;
            end
        end
    end

    // Data registers.
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_pass1 <= i_pass;
        end
        if (w_rdy2) begin
            r_pass2 <= r_pass1;
        end
        if (w_rdy3) begin
            r_pass3 <= r_pass2;
        end
        for (int l = 0; l < 2; l++) begin
            if (w_rdy1) begin
                r_neg1[l] <= w_in[l][WORK_BITS-1];
                r_mag1[l] <= n_mag[l];
                r_raw1[l] <= n_raw[l];
            end
            if (w_rdy2) begin
                r_neg2[l] <= r_neg1[l];
                r_phi2[l] <= n_phi[l];
                r_plo2[l] <= w_plo[l][2*GAIN_BITS-1:GAIN_BITS];
                r_raw2[l] <= r_raw1[l];
            end
            if (w_rdy3) begin
                r_neg3[l] <= r_neg2[l];
                r_rnd3[l] <= w_sum[l][SUM_BITS-1:GUARD_BITS];
                r_raw3[l] <= r_raw2[l];
            end
        end
        if (w_rdy4) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

@@ sv/axis_vector_rotation.sv @@
// Top level of the 3D axis rotation block: input stage, chain of CORDIC cells, finish stages.
// Depends on avr_pkg, avr_cell and avr_finish.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one vector beat: an axis
//   selector, three signed Q16.16 components and a 16-bit binary angle (65536 = full turn).
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns one rotated vector per
//   input beat, in order. The component on the selected axis passes through; selector three
//   passes the whole vector through.
//   The pipeline has one input stage that folds the angle to the nearest quarter turn,
//   one cell per CORDIC step, and four stages of gain correction, rounding, saturation
//   and output register. Throughput is one beat per cycle while the receiver accepts
//   every beat; every stage is a register with its own valid bit.
//   When the receiver stalls, the output register holds its beat and the stages behind it
//   keep filling until the pipeline is full; o_in_ready then drops. The ready path runs
//   combinationally back through the stage valid bits.
//   Reset (synchronous, active low) empties the pipeline at once; no clearing pass follows.
module axis_vector_rotation #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  avr_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output avr_pkg::t_out_beat o_out_data
);
    import avr_pkg::*;

    localparam logic [PHASE_BITS-1:0] EIGHTH_TURN = PHASE_BITS'(1) << (PHASE_BITS - 3);

    // Input stage registers.
    t_flow                        r_flow0;
    logic [COORD_BITS-1:0]        r_pass0;
    logic signed [WORK_BITS-1:0]  r_a0;
    logic signed [WORK_BITS-1:0]  r_b0;
    logic signed [PHASE_BITS-1:0] r_z0;

    t_flow                        n_flow0;
    logic [COORD_BITS-1:0]        n_pass0;
    logic signed [WORK_BITS-1:0]  n_a0;
    logic signed [WORK_BITS-1:0]  n_b0;
    logic [PHASE_BITS-1:0]        n_z0;
    t_axis                        w_op;
    logic [COORD_BITS-1:0]        w_src_a;
    logic [COORD_BITS-1:0]        w_src_b;
    logic signed [WORK_BITS-1:0]  w_ext_a;
    logic signed [WORK_BITS-1:0]  w_ext_b;
    logic [PHASE_BITS-1:0]        w_phase;
    logic [PHASE_BITS-1:0]        w_qsum;
    logic [1:0]                   w_quad;

    // Links between stages: index 0 is the input stage, index k + 1 is cell k.
    t_flow                        w_flow [0:CORDIC_STEPS];
    logic                         w_ready [0:CORDIC_STEPS];
    logic [COORD_BITS-1:0]        w_pass [0:CORDIC_STEPS];
    logic signed [WORK_BITS-1:0]  w_a [0:CORDIC_STEPS];
    logic signed [WORK_BITS-1:0]  w_b [0:CORDIC_STEPS];
    logic signed [PHASE_BITS-1:0] w_z [0:CORDIC_STEPS];

    assign o_in_ready = !r_flow0.valid || w_ready[0];

    // Pick the rotated pair for the axis and split the angle into quarter turn and residual.
    always_comb begin
        w_op = t_axis'(i_in_data.op);
        case (w_op)
            AXIS_X: begin
                w_src_a = i_in_data.y_in;
                w_src_b = i_in_data.z_in;
                n_pass0 = i_in_data.x_in;
            end
            AXIS_Y: begin
                w_src_a = i_in_data.z_in;
                w_src_b = i_in_data.x_in;
                n_pass0 = i_in_data.y_in;
            end
            default: begin
                w_src_a = i_in_data.x_in;
                w_src_b = i_in_data.y_in;
                n_pass0 = i_in_data.z_in;
            end
        endcase
        w_ext_a = {{(WORK_BITS - COORD_BITS - GUARD_BITS){w_src_a[COORD_BITS-1]}},
                   w_src_a, {GUARD_BITS{1'b0}}};
        w_ext_b = {{(WORK_BITS - COORD_BITS - GUARD_BITS){w_src_b[COORD_BITS-1]}},
                   w_src_b, {GUARD_BITS{1'b0}}};
        w_phase = {i_in_data.turn_angle, {(PHASE_BITS - ANGLE_BITS){1'b0}}};
        w_qsum  = w_phase + EIGHTH_TURN;
        w_quad  = (w_op == AXIS_NONE) ? 2'd0 : w_qsum[PHASE_BITS-1 -: 2];
        n_z0    = w_phase - {w_quad, {(PHASE_BITS - 2){1'b0}}};
        // Exact quarter-turn rotations before the CORDIC.
        case (w_quad)
            2'd0: begin
                n_a0 = w_ext_a;
                n_b0 = w_ext_b;
            end
            2'd1: begin
                n_a0 = -w_ext_b;
                n_b0 = w_ext_a;
            end
            2'd2: begin
                n_a0 = -w_ext_a;
                n_b0 = -w_ext_b;
            end
            default: begin
                n_a0 = w_ext_b;
                n_b0 = -w_ext_a;
            end
        endcase
        n_flow0.valid = i_in_valid;
        n_flow0.op    = w_op;
    end

    // Input stage control register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow0 <= '0;
        end else if (o_in_ready) begin
            r_flow0 <= n_flow0;
        end
    end

    // Input stage data register.
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_pass0 <= n_pass0;
            r_a0    <= n_a0;
            r_b0    <= n_b0;
            r_z0    <= n_z0;
        end
    end

    assign w_flow[0] = r_flow0;
    assign w_pass[0] = r_pass0;
    assign w_a[0]    = r_a0;
    assign w_b[0]    = r_b0;
    assign w_z[0]    = r_z0;

    // One cell per CORDIC step.
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        avr_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flow  (w_flow[k]),
            .o_ready (w_ready[k]),
            .i_pass  (w_pass[k]),
            .i_a     (w_a[k]),
            .i_b     (w_b[k]),
            .i_z     (w_z[k]),
            .o_flow  (w_flow[k+1]),
            .i_ready (w_ready[k+1]),
            .o_pass  (w_pass[k+1]),
            .o_a     (w_a[k+1]),
            .o_b     (w_b[k+1]),
            .o_z     (w_z[k+1])
        );
    end

    // Gain correction, rounding, saturation and output register.
    avr_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (w_flow[CORDIC_STEPS]),
        .o_ready (w_ready[CORDIC_STEPS]),
        .i_pass  (w_pass[CORDIC_STEPS]),
        .i_a     (w_a[CORDIC_STEPS]),
        .i_b     (w_b[CORDIC_STEPS]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for axis_vector_rotation: random and directed vector beats,
// predicted with a bit-exact CORDIC model and compared field by field at the output.
// Depends on avr_pkg for the beat types and axis codes, and on the block itself.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import avr_pkg::*;

    // Prediction constants: step count, guard bits, 1/K in Q0.32, saturation limits and random beat count.
    localparam int           STEPS  = 16;
    localparam int           GUARD  = 8;
    localparam logic [31:0]  INV_K  = 32'd2608131496;
    localparam logic [31:0]  Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0]  Q_MIN  = 32'h8000_0000;
    localparam int           N_RANDOM = 1100;

    // atan(2^-i) in 32-bit turns, step 0 in the top word.
    localparam logic [16*32-1:0] ATAN_TURNS = {
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    typedef struct {
        t_in_beat beat;
        bit       settle;   // hold this beat back until every rotation has come out
    } t_pending;

    logic      i_clk = 1'b1;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_data;

    t_pending  vectors_to_send[$];
    t_out_beat rotations_due[$];

    int        tx_wait = 0;
    bit        tx_idle_on = 1'b1;
    int        rx_wait = 0;
    bit        rx_idle_on = 1'b1;
    int        n_sent = 0;
    int        n_checked = 0;
    int        n_errors = 0;
    int        n_axis[4] = '{0, 0, 0, 0};
    t_pending  next_vec;
    t_out_beat due;

    axis_vector_rotation uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b0;
        #2 i_clk = 1'b1;
    end

    // Rotate the pair (a, b) by a 32-bit turn: exact quarter turns, then CORDIC steps.
    // Returns {a, b}.
    function automatic logic [127:0] turn_pair(logic [63:0] a, logic [63:0] b,
                                               logic [31:0] phase);
        logic [31:0] quarter;
        logic [31:0] resid;
        logic [63:0] acc;
        logic [63:0] t;
        logic [63:0] da;
        logic [63:0] db;
        logic [63:0] step;
        quarter = ((phase + 32'h2000_0000) >> 30) & 32'd3;
        resid   = phase - (quarter << 30);
        acc     = {{32{resid[31]}}, resid};
        for (int k = 0; k < int'(quarter); k++) begin
            t = a;
            a = 64'd0 - b;
            b = t;
        end
        for (int i = 0; i < STEPS; i++) begin
            da   = $signed(b) >>> i;
            db   = $signed(a) >>> i;
            step = {32'd0, ATAN_TURNS[32*(15-i) +: 32]};
            if (!acc[63]) begin
                a   = a - da;
                b   = b + db;
                acc = acc - step;
            end else begin
                a   = a + da;
                b   = b - db;
                acc = acc + step;
            end
        end
        return {a, b};
    endfunction

    // Gain correction, guard-bit rounding (half away from zero) and saturation.
    function automatic logic [31:0] unscale(logic [63:0] v);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] r;
        neg = v[63];
        mag = neg ? 64'd0 - v : v;
        hi  = (mag >> 32) * {32'd0, INV_K};
        lo  = {32'd0, mag[31:0]} * {32'd0, INV_K};
        r   = (hi + (lo >> 32) + (64'd1 << (GUARD - 1))) >> GUARD;
        if (neg) begin
            if (r > {32'd0, Q_MIN})
                r = {32'd0, Q_MIN};
            r = 64'd0 - r;
        end else if (r > {32'd0, Q_MAX}) begin
            r = {32'd0, Q_MAX};
        end
        return r[31:0];
    endfunction

    // Expected output beat for one input beat.
    function automatic t_out_beat rotated_vector(t_in_beat v);
        t_out_beat    r;
        logic [63:0]  x;
        logic [63:0]  y;
        logic [63:0]  z;
        logic [127:0] p;
        logic [31:0]  phase;
        x     = {{32{v.x_in[31]}}, v.x_in} << GUARD;
        y     = {{32{v.y_in[31]}}, v.y_in} << GUARD;
        z     = {{32{v.z_in[31]}}, v.z_in} << GUARD;
        phase = {v.turn_angle, 16'h0000};
        r.x_out = v.x_in;
        r.y_out = v.y_in;
        r.z_out = v.z_in;
        case (t_axis'(v.op))
            AXIS_X: begin
                p = turn_pair(y, z, phase);
                r.y_out = unscale(p[127:64]);
                r.z_out = unscale(p[63:0]);
            end
            AXIS_Y: begin
                p = turn_pair(z, x, phase);
                r.z_out = unscale(p[127:64]);
                r.x_out = unscale(p[63:0]);
            end
            AXIS_Z: begin
                p = turn_pair(x, y, phase);
                r.x_out = unscale(p[127:64]);
                r.y_out = unscale(p[63:0]);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic queue_vector(input t_axis op, input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input logic [15:0] angle,
                                input bit settle);
        t_pending p;
        p.beat.op         = op;
        p.beat.x_in       = x;
        p.beat.y_in       = y;
        p.beat.z_in       = z;
        p.beat.turn_angle = angle;
        p.settle          = settle;
        vectors_to_send.push_back(p);
    endtask

    // Mix of extreme, full-range and moderate Q16.16 values.
    function automatic logic [31:0] random_coord();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = Q_MAX;
                    1:       v = Q_MIN;
                    2:       v = 32'd0;
                    3:       v = 32'hFFFF_FFFF;
                    default: v = 32'h0001_0000;
                endcase
            end
            1, 2, 3, 4: v = $urandom;
            default:    v = $signed($urandom) >>> $urandom_range(4, 20);
        endcase
        return v;
    endfunction

    // Mostly uniform angles, some close to the quarter-turn folding points.
    function automatic logic [15:0] random_angle();
        logic [15:0] a;
        if ($urandom_range(0, 3) == 0)
            a = 16'($urandom_range(0, 7) * 16'h2000) + 16'($urandom_range(0, 4)) - 16'd2;
        else
            a = 16'($urandom_range(0, 65535));
        return a;
    endfunction

    // Sender: one beat at a time from the pending queue, with a random gap after each while gaps are on.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                rotations_due.push_back(rotated_vector(i_in_data));
                n_axis[i_in_data.op]++;
                n_sent++;
                if (n_sent % 50 == 0)
                    tx_idle_on = ($urandom_range(0, 3) != 0);
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_in_valid <= 1'b0;
                end else if (vectors_to_send.size() != 0 &&
                             !(vectors_to_send[0].settle && rotations_due.size() != 0)) begin
                    next_vec = vectors_to_send.pop_front();
                    i_in_data  <= next_vec.beat;
                    i_in_valid <= 1'b1;
                    tx_wait = tx_idle_on ? $urandom_range(0, 15) : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each output beat against the oldest prediction, then stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (rotations_due.size() == 0) begin
                    report_mismatch("output beat with no vector outstanding");
                end else begin
                    due = rotations_due.pop_front();
                    if (o_out_data.x_out !== due.x_out)
                        report_mismatch($sformatf("beat %0d x_out got %h expected %h",
                                                  n_checked, o_out_data.x_out, due.x_out));
                    if (o_out_data.y_out !== due.y_out)
                        report_mismatch($sformatf("beat %0d y_out got %h expected %h",
                                                  n_checked, o_out_data.y_out, due.y_out));
                    if (o_out_data.z_out !== due.z_out)
                        report_mismatch($sformatf("beat %0d z_out got %h expected %h",
                                                  n_checked, o_out_data.z_out, due.z_out));
                end
                n_checked++;
                if (n_checked % 70 == 0)
                    rx_idle_on = ($urandom_range(0, 2) != 0);
                rx_wait = rx_idle_on ? $urandom_range(0, 15) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_out_ready <= (rx_wait == 0);
        end
    end

    // Stimulus and end of run.
    initial begin
        t_axis ax;

        // Directed: fixed angles per axis on a plain vector.
        for (int k = 0; k < 3; k++) begin
            ax = t_axis'(k);
            queue_vector(ax, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 16'h0000, 1'b0);
            queue_vector(ax, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 16'h4000, 1'b0);
            queue_vector(ax, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 16'h8000, 1'b0);
            queue_vector(ax, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000, 16'hC000, 1'b0);
            // Diagonal turn on the largest and smallest vectors saturates.
            queue_vector(ax, Q_MAX, Q_MAX, Q_MAX, 16'h2000, 1'b0);
            queue_vector(ax, Q_MIN, Q_MIN, Q_MIN, 16'h2000, 1'b0);
        end
        // Angles on either side of the quarter-turn fold, and the last step before a turn.
        queue_vector(AXIS_Z, Q_MIN, Q_MAX, 32'h0000_0001, 16'h1FFF, 1'b0);
        queue_vector(AXIS_Z, Q_MIN, Q_MAX, 32'h0000_0001, 16'h2000, 1'b0);
        queue_vector(AXIS_X, 32'h1234_5678, 32'hFFFF_FFFF, Q_MIN, 16'hFFFF, 1'b0);
        // No axis selected: the vector passes through.
        queue_vector(AXIS_NONE, 32'hDEAD_BEEF, Q_MIN, Q_MAX, 16'h5A5A, 1'b0);

        // Random part; twice the sender drains the pipeline before going on.
        for (int k = 0; k < N_RANDOM; k++) begin
            ax = ($urandom_range(0, 15) == 0) ? AXIS_NONE : t_axis'($urandom_range(0, 2));
            queue_vector(ax, random_coord(), random_coord(), random_coord(), random_angle(),
                         k == 0 || k == N_RANDOM / 2);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (vectors_to_send.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (rotations_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d vectors: %0d about X, %0d about Y, %0d about Z, %0d with no axis.",
                 n_sent, n_axis[0], n_axis[1], n_axis[2], n_axis[3]);
        $display("Compared %0d output beats field by field, %0d mismatches.",
                 n_checked, n_errors);
        if (n_errors == 0)
            $display("[axis_vector_rotation] OK");
        else
            $display("[axis_vector_rotation] ERROR");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("[axis_vector_rotation] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/avr_pkg.sv
sv/avr_cell.sv
sv/avr_finish.sv
sv/axis_vector_rotation.sv
tb/sv/tb.sv
